// ===== hw/rtl/udp_dc_pkg.sv =====
package udp_dc_pkg;

    localparam int unsigned COUNT_W      = 17;
    localparam int unsigned IN_DATA_W    = 72;
    localparam int unsigned OUT_DATA_W   = 56;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
    localparam logic [COUNT_W-1:0] HEADER_BYTES = 17'd8;
    localparam logic [15:0]        UDP_PROTOCOL = 16'd17;
    localparam logic [15:0]        SUM_GOOD     = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_SHORT = 2'd1,
        ST_LEN_ERR   = 2'd2,
        ST_BAD_SUM   = 2'd3
    } status_t;

    // Everything the evaluation stage needs about one finished datagram.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [15:0]        sum;
        logic [63:0]        header;
        logic [63:0]        addr;
    } snap_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] payload_length;
        logic        checksum_skipped;
    } result_t;

    // Ones' complement add with end-around carry.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return 16'(s[15:0] + {15'b0, s[16]});
    endfunction

endpackage

// ===== hw/rtl/udp_dc_accum.sv =====
module udp_dc_accum
    import udp_dc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    input  logic                 adv,
    output logic                 snap_valid,
    output snap_t                snap
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [15:0]        sum_reg, sum_next;
    logic [7:0]         hold_reg, hold_next;
    logic [63:0]        header_reg, header_next;
    logic [63:0]        addr_reg, addr_next;
    logic               snap_valid_reg, snap_valid_next;
    snap_t              snap_reg, snap_next;
    logic               accept;
    logic [7:0]         data_b;
    logic [15:0]        word;
    logic [15:0]        sum_added;

    assign data_b   = s_tdata[7:0];
    assign s_tready = !snap_valid_reg || adv;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        // An even position opens a word; at the final byte it is padded with zero.
        word        = count_reg[0] ? {hold_reg, data_b} : {data_b, 8'h00};
        sum_added   = oc_add(sum_reg, word);
        sum_next    = count_reg[0] ? sum_added : sum_reg;
        hold_next   = count_reg[0] ? hold_reg : data_b;
        header_next = (count_reg < HEADER_BYTES) ? {header_reg[55:0], data_b} : header_reg;
        addr_next   = (count_reg == '0) ? {s_tdata[39:8], s_tdata[71:40]} : addr_reg;
        count_next  = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

        snap_next.count  = count_next;
        snap_next.sum    = sum_added;
        snap_next.header = header_next;
        snap_next.addr   = addr_next;

        snap_valid_next = (snap_valid_reg && !adv) || (accept && s_tlast);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            sum_reg        <= '0;
            hold_reg       <= '0;
            header_reg     <= '0;
            addr_reg       <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
            if (accept)
            begin
                if (s_tlast)
                begin
                    count_reg  <= '0;
                    sum_reg    <= '0;
                    hold_reg   <= '0;
                    header_reg <= '0;
                    addr_reg   <= '0;
                end
                else
                begin
                    count_reg  <= count_next;
                    sum_reg    <= sum_next;
                    hold_reg   <= hold_next;
                    header_reg <= header_next;
                    addr_reg   <= addr_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_tlast)
        begin
            snap_reg <= snap_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

// ===== hw/rtl/udp_dc_eval.sv =====
module udp_dc_eval
    import udp_dc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  snap_valid,
    input  snap_t snap,
    output logic  adv,
    output logic  out_valid,
    input  logic  out_ready,
    output result_t result
);

    logic        out_valid_reg;
    result_t     result_reg, result_next;
    logic [18:0] total;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] ulen;
    logic [15:0] csum;

    assign adv = !out_valid_reg || out_ready;

    always_comb
    begin
        ulen  = snap.header[31:16];
        csum  = snap.header[15:0];
        total = {3'b0, snap.sum}
              + {3'b0, snap.addr[63:48]} + {3'b0, snap.addr[47:32]}
              + {3'b0, snap.addr[31:16]} + {3'b0, snap.addr[15:0]}
              + {3'b0, UDP_PROTOCOL} + {3'b0, snap.count[15:0]};
        fold1 = {1'b0, total[15:0]} + {14'b0, total[18:16]};
        fold2 = 16'(fold1[15:0] + {15'b0, fold1[16]});

        result_next.source_port      = snap.header[63:48];
        result_next.dest_port        = snap.header[47:32];
        result_next.checksum_skipped = (csum == '0);
        result_next.payload_length   = '0;
        result_next.status           = ST_OK;

        if (snap.count < HEADER_BYTES)
        begin
            result_next.status           = ST_TOO_SHORT;
            result_next.source_port      = '0;
            result_next.dest_port        = '0;
            result_next.checksum_skipped = 1'b0;
        end
        else if ({1'b0, ulen} != snap.count)
        begin
            result_next.status = ST_LEN_ERR;
        end
        else if (csum != '0 && fold2 != SUM_GOOD)
        begin
            result_next.status = ST_BAD_SUM;
        end
        else
        begin
            result_next.payload_length = 16'(snap.count - HEADER_BYTES);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && snap_valid)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ===== hw/rtl/udp_datagram_checker.sv =====
// Channel | Dir | Handshake          | Word
// s_axis  | in  | s_tvalid/s_tready  | one datagram byte plus addresses, s_tlast on the final byte
// m_axis  | out | m_tvalid/m_tready  | one check result per datagram
//
// A byte is taken every cycle unless stalled; a result passes the snapshot, then the output register.
// The per-byte checksum add and the final pseudo-header sum each take one register stage.
// Reset clears the running sum, byte count and header capture, and empties both stages.
// A stalled result holds in the output register; input stalls only when both stages are full.
module udp_datagram_checker
    import udp_dc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // data_byte [7:0], source_address [39:8], dest_address [71:40]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status [1:0], source_port [17:2], dest_port [33:18], payload_length [49:34],
    // checksum_skipped [50], zero [55:51]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic    adv;
    logic    snap_valid;
    snap_t   snap;
    result_t result;

    udp_dc_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .adv        (adv),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    udp_dc_eval u_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap       (snap),
        .adv        (adv),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .result     (result)
    );

    assign m_tdata = {5'b0, result.checksum_skipped, result.payload_length,
                      result.dest_port, result.source_port, result.status};

    a_final_to_snap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> snap_valid)
        else $error("final byte did not reach the evaluation stage");

    a_snap_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid && adv |=> m_tvalid)
        else $error("evaluated datagram did not reach the output");

    a_short_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && result.status == ST_TOO_SHORT |->
            result.source_port == '0 && result.dest_port == '0 && !result.checksum_skipped)
        else $error("short datagram reported header fields");

    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && result.status != ST_OK |-> result.payload_length == '0)
        else $error("failed datagram reported a payload length");

endmodule

// ===== tb/tb_top.sv =====
module tb_top
    import udp_dc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0]  data;
        logic        last;
        logic [31:0] src;
        logic [31:0] dst;
        bit          drain;
    } word_t;

    typedef enum int {
        DG_GOOD,
        DG_NO_SUM,
        DG_BAD_SUM,
        DG_BAD_LEN,
        DG_NOISE
    } dg_kind_t;

    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned QUIET_WORDS = 100;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    word_t   feed [$];
    result_t expected_results [$];
    word_t   offered;

    logic [COUNT_W-1:0] rx_count = '0;
    logic [15:0]        rx_sum = '0;
    logic [7:0]         rx_high = '0;
    logic [63:0]        rx_header = '0;
    logic [63:0]        rx_addr = '0;

    int unsigned words_sent = 0;
    int unsigned results_checked = 0;
    int unsigned datagrams = 0;
    int unsigned errors = 0;
    int unsigned send_gap = 0;
    int unsigned send_pct = 0;
    int unsigned send_phase = 0;
    int unsigned hold_left = 0;
    int unsigned hold_pct = 0;
    int unsigned hold_phase = 0;
    bit          long_hold_done = 0;

    udp_datagram_checker uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] t;
        t = 17'(a) + 17'(b);
        return t[15:0] + 16'(t[16]);
    endfunction

    function automatic int unsigned pick_pct();
        int unsigned r;
        r = $urandom_range(0, 2);
        return (r == 0) ? 0 : (r == 1) ? 15 : 40;
    endfunction

    function automatic logic [31:0] pick_addr();
        int unsigned r;
        r = $urandom_range(0, 9);
        return (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : 32'($urandom);
    endfunction

    task automatic add_datagram(input int unsigned n, input dg_kind_t kind,
                                input logic [15:0] sport, input logic [15:0] dport,
                                input logic [31:0] src, input logic [31:0] dst,
                                input bit drain);
        logic [7:0]  b [];
        logic [15:0] ulen;
        logic [15:0] csum;
        logic [15:0] s;
        word_t       w;
        b = new[n];
        foreach (b[i]) b[i] = 8'($urandom);
        if (kind != DG_NOISE && n >= 8) begin
            ulen = 16'(n);
            if (kind == DG_BAD_LEN)
                ulen ^= 16'(1 << $urandom_range(0, 15));
            b[0] = sport[15:8];
            b[1] = sport[7:0];
            b[2] = dport[15:8];
            b[3] = dport[7:0];
            b[4] = ulen[15:8];
            b[5] = ulen[7:0];
            b[6] = 8'h00;
            b[7] = 8'h00;
            csum = 16'h0;
            if (kind == DG_GOOD || kind == DG_BAD_SUM) begin
                s = 16'h0;
                for (int i = 0; i < n; i += 2)
                    s = ones_add(s, {b[i], (i + 1 < n) ? b[i+1] : 8'h00});
                s = ones_add(s, src[31:16]);
                s = ones_add(s, src[15:0]);
                s = ones_add(s, dst[31:16]);
                s = ones_add(s, dst[15:0]);
                s = ones_add(s, UDP_PROTOCOL);
                s = ones_add(s, 16'(n));
                csum = ~s;
                if (csum == 16'h0)
                    csum = 16'hFFFF;
                if (kind == DG_BAD_SUM)
                    csum ^= 16'($urandom_range(1, 65535));
            end
            b[6] = csum[15:8];
            b[7] = csum[7:0];
        end
        foreach (b[i]) begin
            w.data  = b[i];
            w.last  = (i == n - 1);
            w.src   = (i == 0) ? src : 32'($urandom);
            w.dst   = (i == 0) ? dst : 32'($urandom);
            w.drain = drain && (i == 0);
            feed.push_back(w);
        end
        datagrams++;
    endtask

    // Mirrors the checker on every accepted word and queues the result of a final byte.
    task automatic track_word(input word_t w);
        result_t     r;
        logic [15:0] s;
        logic [15:0] ulen;
        logic [15:0] csum;
        if (rx_count == '0)
            rx_addr = {w.src, w.dst};
        if (rx_count < HEADER_BYTES)
            rx_header = {rx_header[55:0], w.data};
        if (!rx_count[0])
            rx_high = w.data;
        else
            rx_sum = ones_add(rx_sum, {rx_high, w.data});
        if (rx_count != COUNT_MAX)
            rx_count++;
        if (w.last) begin
            ulen = rx_header[31:16];
            csum = rx_header[15:0];
            r.source_port      = rx_header[63:48];
            r.dest_port        = rx_header[47:32];
            r.payload_length   = 16'h0;
            r.checksum_skipped = (csum == 16'h0);
            if (rx_count < HEADER_BYTES) begin
                r.status           = ST_TOO_SHORT;
                r.source_port      = 16'h0;
                r.dest_port        = 16'h0;
                r.checksum_skipped = 1'b0;
            end else if (COUNT_W'(ulen) != rx_count) begin
                r.status = ST_LEN_ERR;
            end else if (csum == 16'h0) begin
                r.status         = ST_OK;
                r.payload_length = 16'(rx_count - HEADER_BYTES);
            end else begin
                s = rx_sum;
                if (rx_count[0])
                    s = ones_add(s, {rx_high, 8'h00});
                s = ones_add(s, rx_addr[63:48]);
                s = ones_add(s, rx_addr[47:32]);
                s = ones_add(s, rx_addr[31:16]);
                s = ones_add(s, rx_addr[15:0]);
                s = ones_add(s, UDP_PROTOCOL);
                s = ones_add(s, rx_count[15:0]);
                if (s == SUM_GOOD) begin
                    r.status         = ST_OK;
                    r.payload_length = 16'(rx_count - HEADER_BYTES);
                end else begin
                    r.status = ST_BAD_SUM;
                end
            end
            expected_results.push_back(r);
            rx_count  = '0;
            rx_sum    = '0;
            rx_high   = '0;
            rx_header = '0;
            rx_addr   = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_word(offered);
                words_sent++;
                if (send_phase == 0) begin
                    send_pct   = pick_pct();
                    send_phase = $urandom_range(20, 120);
                end else begin
                    send_phase--;
                end
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (feed.size() == 0 ||
                             (feed[0].drain && expected_results.size() != 0)) begin
                    s_tvalid <= 1'b0;
                end else if (feed.size() >= QUIET_WORDS &&
                             $urandom_range(0, 99) < send_pct) begin
                    send_gap = $urandom_range(0, 3);
                    s_tvalid <= 1'b0;
                end else begin
                    offered = feed.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {offered.dst, offered.src, offered.data};
                    s_tlast  <= offered.last;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        result_t got;
        result_t want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status           = status_t'(m_tdata[1:0]);
                got.source_port      = m_tdata[17:2];
                got.dest_port        = m_tdata[33:18];
                got.payload_length   = m_tdata[49:34];
                got.checksum_skipped = m_tdata[50];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %s sport=%h dport=%h len=%0d skip=%b",
                             $time, got.status.name(), got.source_port, got.dest_port,
                             got.payload_length, got.checksum_skipped);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected %s sport=%h dport=%h len=%0d skip=%b",
                                 $time, want.status.name(), want.source_port,
                                 want.dest_port, want.payload_length, want.checksum_skipped);
                        $display("%0t: actual   %s sport=%h dport=%h len=%0d skip=%b",
                                 $time, got.status.name(), got.source_port,
                                 got.dest_port, got.payload_length, got.checksum_skipped);
                        errors++;
                    end
                end
                results_checked++;
            end
            if (hold_phase == 0) begin
                hold_pct   = pick_pct();
                hold_phase = $urandom_range(50, 300);
            end else begin
                hold_phase--;
            end
            if (!long_hold_done && results_checked >= 6) begin
                long_hold_done = 1;
                hold_left      = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (feed.size() >= QUIET_WORDS && $urandom_range(0, 99) < hold_pct) begin
                hold_left = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned random_words;
        int unsigned n;
        int unsigned r;
        dg_kind_t    kind;

        // Short headers, all-ones ports with no checksum, and an odd-length good datagram.
        add_datagram(1, DG_NOISE, 16'h0, 16'h0, 32'h0, 32'hFFFF_FFFF, 0);
        add_datagram(7, DG_NOISE, 16'h0, 16'h0, 32'hFFFF_FFFF, 32'h0, 0);
        add_datagram(8, DG_NO_SUM, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        add_datagram(9, DG_GOOD, 16'h0, 16'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);

        random_words = 0;
        for (int d = 0; random_words < 850; d++) begin
            r = $urandom_range(0, 99);
            n = (r < 10) ? $urandom_range(1, 7) :
                (r < 85) ? $urandom_range(8, 24) : $urandom_range(25, 120);
            r = $urandom_range(0, 19);
            kind = (r < 9) ? DG_GOOD : (r < 12) ? DG_NO_SUM : (r < 15) ? DG_BAD_SUM :
                   (r < 18) ? DG_BAD_LEN : DG_NOISE;
            add_datagram(n, kind, 16'($urandom), 16'($urandom), pick_addr(), pick_addr(),
                         d == 0 || d == 25);
            random_words += n;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (feed.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d datagrams in %0d words, %0d results checked.", datagrams, words_sent,
                 results_checked);
        $display("Covered short, mismatched, bad and skipped checksums and a %0d-cycle stall.",
                 LONG_HOLD);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout with %0d words left to send.", feed.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
